// ===== design/sdc_pkg.sv =====
// Shared constants, register map and command codes of the sector disk controller.
// Depends on nothing; the controller refers to it by scoped names.
package sdc_pkg;

  localparam int MAX_SECTOR   = 2048;
  localparam int SECTOR_BYTES = 128;
  localparam int STORE_BYTES  = (MAX_SECTOR + 1) * SECTOR_BYTES;

  localparam int BUF_AW   = $clog2(SECTOR_BYTES);
  localparam int CNT_W    = BUF_AW + 1;
  localparam int SEC_AW   = $clog2(MAX_SECTOR + 1);
  localparam int STORE_AW = $clog2(STORE_BYTES);
  localparam int EXT_W    = $clog2(MAX_SECTOR + 2);

  // Register map above the transfer buffer.
  localparam logic [7:0] ADDR_SECTOR_LO = 8'h80;
  localparam logic [7:0] ADDR_SECTOR_HI = 8'h81;
  localparam logic [7:0] ADDR_COMMAND   = 8'h82;

  // Command codes written to the command register.
  localparam logic [7:0] CMD_NOP          = 8'd0;
  localparam logic [7:0] CMD_LABEL_LOAD   = 8'd1;
  localparam logic [7:0] CMD_LABEL_SAVE   = 8'd2;
  localparam logic [7:0] CMD_SERIAL       = 8'd3;
  localparam logic [7:0] CMD_SECTOR_READ  = 8'd4;
  localparam logic [7:0] CMD_SECTOR_WRITE = 8'd5;

  localparam logic [7:0] STATUS_OK    = 8'd0;
  localparam logic [7:0] STATUS_ERROR = 8'hFF;

  localparam int SERIAL_LEN = 8;

  // ASCII "deadbeef", one character per index.
  function automatic logic [7:0] serial_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h64;
      3'd1: ch = 8'h65;
      3'd2: ch = 8'h61;
      3'd3: ch = 8'h64;
      3'd4: ch = 8'h62;
      3'd5: ch = 8'h65;
      3'd6: ch = 8'h65;
      3'd7: ch = 8'h66;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/sector_disk_controller.sv =====
// Sector disk controller: byte-wide bus window onto a transfer buffer, sector and
// command registers, a label store and a disk store. Uses sdc_pkg.
//
// A plain buffer or register access goes through decode and the response state before
// its read item is registered; a command write also goes through one copy sweep.
// Throughput: one item at a time; the 128-entry byte copy through the shared copy
// datapath, with one memory read and one memory write per cycle, sets the command time.
// Reset (synchronous, rst_n low) clears all control state and then runs a clearing pass
// over the disk store, one byte per cycle, before the first item.
module sector_disk_controller (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: disk_present.
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // Bus access items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] address, [15:8] write_data
  input  logic        in_tuser,   // [0] mode (0 read, 1 write)
  // Read data items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [7:0] read_data
);

  localparam int BUF_AW   = sdc_pkg::BUF_AW;
  localparam int CNT_W    = sdc_pkg::CNT_W;
  localparam int SEC_AW   = sdc_pkg::SEC_AW;
  localparam int STORE_AW = sdc_pkg::STORE_AW;
  localparam int EXT_W    = sdc_pkg::EXT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_COPY,
    S_RESP
  } state_t;

  // Memories. The buffer and the label get valid bits so that reset reads them as zero;
  // the disk store is swept to zero after reset instead.
  logic [7:0] buf_mem [sdc_pkg::SECTOR_BYTES];
  logic [7:0] lbl_mem [sdc_pkg::SECTOR_BYTES];
  logic [7:0] st_mem  [sdc_pkg::STORE_BYTES];

  state_t               state_r, state_nxt;
  logic                 present_r;
  logic                 mode_r, mode_nxt;
  logic [7:0]           addr_r, addr_nxt;
  logic [7:0]           wdata_r, wdata_nxt;
  logic [15:0]          sector_r, sector_nxt;
  logic [7:0]           status_r, status_nxt;
  logic [EXT_W-1:0]     ext_r, ext_nxt;
  logic [7:0]           op_r, op_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 zero_seen_r, zero_seen_nxt;
  logic [STORE_AW-1:0]  clr_r, clr_nxt;
  logic [7:0]           rd_r, rd_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [7:0]           out_data_r, out_data_nxt;
  logic                 buf_vld_r [sdc_pkg::SECTOR_BYTES];
  logic                 lbl_vld_r [sdc_pkg::SECTOR_BYTES];

  // Registered memory read data.
  logic [7:0]           buf_q_r, lbl_q_r, st_q_r;
  logic                 buf_qv_r, lbl_qv_r;

  logic [BUF_AW-1:0]    buf_raddr;
  logic [STORE_AW-1:0]  st_raddr;
  logic                 buf_we, lbl_we, st_we;
  logic [BUF_AW-1:0]    buf_waddr, lbl_waddr;
  logic [7:0]           buf_wdata, lbl_wdata, st_wdata;
  logic [STORE_AW-1:0]  st_waddr;
  logic [BUF_AW-1:0]    step_idx;
  logic [7:0]           src_byte;
  logic [7:0]           buf_byte;
  logic [16:0]          sector_plus1;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // The buffer is read at the incoming address while idle, else at the sweep index.
  assign buf_raddr = (state_r == S_IDLE) ? in_tdata[BUF_AW-1:0] : cnt_r[BUF_AW-1:0];
  assign st_raddr  = {sector_r[SEC_AW-1:0], cnt_r[BUF_AW-1:0]};

  // The sweep writes the byte read in the cycle before, so the write index trails by one.
  assign step_idx     = BUF_AW'(cnt_r - CNT_W'(1));
  assign buf_byte     = buf_qv_r ? buf_q_r : 8'h00;
  assign sector_plus1 = {1'b0, sector_r} + 17'd1;

  // Shared copy datapath: selects the byte that the current command moves.
  always_comb begin
    case (op_r)
      sdc_pkg::CMD_LABEL_LOAD:   src_byte = lbl_qv_r ? lbl_q_r : 8'h00;
      sdc_pkg::CMD_LABEL_SAVE:   src_byte = buf_byte;
      sdc_pkg::CMD_SECTOR_WRITE: src_byte = buf_byte;
      sdc_pkg::CMD_SECTOR_READ:  src_byte = st_q_r;
      sdc_pkg::CMD_SERIAL:
        src_byte = (step_idx < BUF_AW'(sdc_pkg::SERIAL_LEN)) ?
                   sdc_pkg::serial_char(step_idx[2:0]) : 8'h00;
      default: src_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    addr_nxt      = addr_r;
    wdata_nxt     = wdata_r;
    sector_nxt    = sector_r;
    status_nxt    = status_r;
    ext_nxt       = ext_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    zero_seen_nxt = zero_seen_r;
    clr_nxt       = clr_r;
    rd_nxt        = rd_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_data_nxt  = out_data_r;
    buf_we        = 1'b0;
    buf_waddr     = addr_r[BUF_AW-1:0];
    buf_wdata     = wdata_r;
    lbl_we        = 1'b0;
    lbl_waddr     = step_idx;
    lbl_wdata     = 8'h00;
    st_we         = 1'b0;
    st_waddr      = {sector_r[SEC_AW-1:0], step_idx};
    st_wdata      = src_byte;

    case (state_r)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        st_wdata = 8'h00;
        if (clr_r == STORE_AW'(sdc_pkg::STORE_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + STORE_AW'(1);
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_tuser;
          addr_nxt  = in_tdata[7:0];
          wdata_nxt = in_tdata[15:8];
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        rd_nxt    = 8'h00;
        state_nxt = S_RESP;
        if (!mode_r) begin
          if (!addr_r[7]) begin
            rd_nxt = buf_byte;
          end else if (addr_r == sdc_pkg::ADDR_SECTOR_LO) begin
            rd_nxt = sector_r[7:0];
          end else if (addr_r == sdc_pkg::ADDR_SECTOR_HI) begin
            rd_nxt = sector_r[15:8];
          end else if (addr_r == sdc_pkg::ADDR_COMMAND) begin
            rd_nxt = status_r;
          end
        end else if (!addr_r[7]) begin
          buf_we = 1'b1;
        end else if (addr_r == sdc_pkg::ADDR_SECTOR_LO) begin
          sector_nxt = {sector_r[15:8], wdata_r};
        end else if (addr_r == sdc_pkg::ADDR_SECTOR_HI) begin
          sector_nxt = {wdata_r, sector_r[7:0]};
        end else if (addr_r == sdc_pkg::ADDR_COMMAND) begin
          // Every command fails at once, finishes at once as a no-op, or starts a sweep with status already 0.
          op_nxt        = wdata_r;
          cnt_nxt       = '0;
          zero_seen_nxt = 1'b0;
          status_nxt    = sdc_pkg::STATUS_ERROR;
          if (present_r) begin
            case (wdata_r)
              sdc_pkg::CMD_NOP: begin
                status_nxt = sdc_pkg::STATUS_OK;
              end
              sdc_pkg::CMD_LABEL_LOAD, sdc_pkg::CMD_LABEL_SAVE, sdc_pkg::CMD_SERIAL: begin
                status_nxt = sdc_pkg::STATUS_OK;
                state_nxt  = S_COPY;
              end
              sdc_pkg::CMD_SECTOR_READ: begin
                if (sector_r <= 16'(sdc_pkg::MAX_SECTOR) &&
                    sector_r < 16'(ext_r)) begin
                  status_nxt = sdc_pkg::STATUS_OK;
                  state_nxt  = S_COPY;
                end
              end
              sdc_pkg::CMD_SECTOR_WRITE: begin
                if (sector_r <= 16'(sdc_pkg::MAX_SECTOR)) begin
                  status_nxt = sdc_pkg::STATUS_OK;
                  state_nxt  = S_COPY;
                  if (17'(ext_r) < sector_plus1) begin
                    ext_nxt = EXT_W'(sector_plus1);
                  end
                end
              end
              default: begin
                status_nxt = sdc_pkg::STATUS_ERROR;
              end
            endcase
          end
        end
      end

      S_COPY: begin
        if (cnt_r != '0) begin
          case (op_r)
            sdc_pkg::CMD_LABEL_LOAD, sdc_pkg::CMD_SERIAL, sdc_pkg::CMD_SECTOR_READ: begin
              buf_we    = 1'b1;
              buf_waddr = step_idx;
              buf_wdata = src_byte;
            end
            sdc_pkg::CMD_LABEL_SAVE: begin
              // Everything from the first zero byte on is stored as zero.
              lbl_we        = 1'b1;
              lbl_wdata     = (zero_seen_r || src_byte == 8'h00) ? 8'h00 : src_byte;
              zero_seen_nxt = zero_seen_r || (src_byte == 8'h00);
            end
            sdc_pkg::CMD_SECTOR_WRITE: begin
              st_we = 1'b1;
            end
            default: begin
            end
          endcase
        end
        if (cnt_r == CNT_W'(sdc_pkg::SECTOR_BYTES)) begin
          state_nxt = S_RESP;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      S_RESP: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = rd_r;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      present_r   <= 1'b0;
      sector_r    <= '0;
      status_r    <= '0;
      ext_r       <= '0;
      op_r        <= '0;
      cnt_r       <= '0;
      zero_seen_r <= 1'b0;
      clr_r       <= '0;
      out_vld_r   <= 1'b0;
      for (int i = 0; i < sdc_pkg::SECTOR_BYTES; i++) begin
        buf_vld_r[i] <= 1'b0;
        lbl_vld_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        present_r <= cfg_wdata;
      end
      sector_r    <= sector_nxt;
      status_r    <= status_nxt;
      ext_r       <= ext_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      zero_seen_r <= zero_seen_nxt;
      clr_r       <= clr_nxt;
      out_vld_r   <= out_vld_nxt;
      if (buf_we) begin
        buf_vld_r[buf_waddr] <= 1'b1;
      end
      if (lbl_we) begin
        lbl_vld_r[lbl_waddr] <= 1'b1;
      end
    end
    mode_r     <= mode_nxt;
    addr_r     <= addr_nxt;
    wdata_r    <= wdata_nxt;
    rd_r       <= rd_nxt;
    out_data_r <= out_data_nxt;
    buf_qv_r   <= buf_vld_r[buf_raddr];
    lbl_qv_r   <= lbl_vld_r[cnt_r[BUF_AW-1:0]];
  end

  // Transfer buffer.
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
    buf_q_r <= buf_mem[buf_raddr];
  end

  // Label store.
  always_ff @(posedge clk) begin
    if (lbl_we) begin
      lbl_mem[lbl_waddr] <= lbl_wdata;
    end
    lbl_q_r <= lbl_mem[cnt_r[BUF_AW-1:0]];
  end

  // Disk store.
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_q_r <= st_mem[st_raddr];
  end

  // An accepted item always goes straight to decode.
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DECODE))
    else $error("accepted item did not enter decode");

  // A running sweep only exists for a command that passed its checks.
  a_copy_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> (status_r == sdc_pkg::STATUS_OK && present_r))
    else $error("copy sweep running with failed status or no disk");

  // The sweep counter never runs past one sector.
  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> (cnt_r <= CNT_W'(sdc_pkg::SECTOR_BYTES)))
    else $error("copy sweep counter out of range");

  // The written extent never exceeds the number of sectors on the disk.
  a_extent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ext_r <= EXT_W'(sdc_pkg::MAX_SECTOR + 1))
    else $error("written extent beyond disk size");

endmodule

// ===== tb/sv/sector_disk_controller_tb.sv =====
// Self-checking testbench for the sector disk controller: bus access items in, read data out.
// Depends on sdc_pkg and sector_disk_controller; a scoreboard class tracks controller state.
`timescale 1ns / 100ps

module sector_disk_controller_tb;

  // The limit covers the reset clearing pass; the rest allows every item to be a
  // full copy command with the worst gaps and stalls, several times over.
  localparam int unsigned CYCLE_LIMIT = 1200000;
  localparam int HOLD_CYCLES = 600;
  localparam int MAX_GAP = 13;
  localparam int DRAIN_CYCLES = 150;

  // Command codes the controller must reject.
  localparam logic [7:0] CMD_FIRST_UNKNOWN = sdc_pkg::CMD_SECTOR_WRITE + 8'd1;
  localparam logic [7:0] CMD_LAST_UNKNOWN  = 8'hFF;

  // Tracks the controller's buffer, registers, label and disk, and holds the read data
  // that each accepted bus item must return, oldest first.
  class read_data_scoreboard;
    logic [7:0] xfer_buf [sdc_pkg::SECTOR_BYTES];
    logic [7:0] label_bytes [sdc_pkg::SECTOR_BYTES];
    logic [7:0] disk_bytes [int unsigned];
    logic [15:0] sector_reg;
    logic [7:0] status_reg;
    int unsigned extent;
    bit present;
    logic [7:0] expected_read_data [$];
    int failures;
    int accesses;
    int commands;
    int failed_commands;
    int checked;

    localparam logic [63:0] SERIAL_TEXT = "deadbeef";

    function new();
      foreach (xfer_buf[i]) begin
        xfer_buf[i] = 8'h00;
        label_bytes[i] = 8'h00;
      end
      sector_reg = 16'h0000;
      status_reg = sdc_pkg::STATUS_OK;
      extent = 0;
      present = 1'b0;
      failures = 0;
      accesses = 0;
      commands = 0;
      failed_commands = 0;
      checked = 0;
    endfunction

    function void set_disk_present(bit value);
      present = value;
    endfunction

    // Runs the command just written to the command register.
    function void run_command();
      int unsigned base;
      bit failed;
      bit stop;
      failed = 1'b0;
      commands++;
      if (!present) begin
        failed = 1'b1;
      end else begin
        base = sector_reg * sdc_pkg::SECTOR_BYTES;
        case (status_reg)
          sdc_pkg::CMD_NOP: ;
          sdc_pkg::CMD_LABEL_LOAD: xfer_buf = label_bytes;
          sdc_pkg::CMD_LABEL_SAVE: begin
            // The label ends at the first zero; a buffer without one fills all of it.
            stop = 1'b0;
            for (int i = 0; i < sdc_pkg::SECTOR_BYTES; i++) begin
              if (xfer_buf[i] == 8'h00) stop = 1'b1;
              label_bytes[i] = stop ? 8'h00 : xfer_buf[i];
            end
          end
          sdc_pkg::CMD_SERIAL: begin
            for (int i = 0; i < sdc_pkg::SECTOR_BYTES; i++)
              xfer_buf[i] = (i < sdc_pkg::SERIAL_LEN) ? SERIAL_TEXT[63 - 8 * i -: 8] : 8'h00;
          end
          sdc_pkg::CMD_SECTOR_READ: begin
            if (sector_reg > sdc_pkg::MAX_SECTOR || sector_reg >= extent) begin
              failed = 1'b1;
            end else begin
              // Sectors skipped by an earlier write were never stored and read as zero.
              for (int i = 0; i < sdc_pkg::SECTOR_BYTES; i++)
                xfer_buf[i] = disk_bytes.exists(base + i) ? disk_bytes[base + i] : 8'h00;
            end
          end
          sdc_pkg::CMD_SECTOR_WRITE: begin
            if (sector_reg > sdc_pkg::MAX_SECTOR) begin
              failed = 1'b1;
            end else begin
              for (int i = 0; i < sdc_pkg::SECTOR_BYTES; i++)
                disk_bytes[base + i] = xfer_buf[i];
              if (extent < sector_reg + 1) extent = sector_reg + 1;
            end
          end
          default: failed = 1'b1;
        endcase
      end
      if (failed) begin
        status_reg = sdc_pkg::STATUS_ERROR;
        failed_commands++;
      end else begin
        status_reg = sdc_pkg::STATUS_OK;
      end
    endfunction

    function void note_access(bit is_write, logic [7:0] addr, logic [7:0] data);
      logic [7:0] rd;
      rd = 8'h00;
      accesses++;
      if (!is_write) begin
        if (addr < sdc_pkg::SECTOR_BYTES) rd = xfer_buf[addr[6:0]];
        else if (addr == sdc_pkg::ADDR_SECTOR_LO) rd = sector_reg[7:0];
        else if (addr == sdc_pkg::ADDR_SECTOR_HI) rd = sector_reg[15:8];
        else if (addr == sdc_pkg::ADDR_COMMAND) rd = status_reg;
      end else begin
        if (addr < sdc_pkg::SECTOR_BYTES) begin
          xfer_buf[addr[6:0]] = data;
        end else if (addr == sdc_pkg::ADDR_SECTOR_LO) begin
          sector_reg[7:0] = data;
        end else if (addr == sdc_pkg::ADDR_SECTOR_HI) begin
          sector_reg[15:8] = data;
        end else if (addr == sdc_pkg::ADDR_COMMAND) begin
          status_reg = data;
          run_command();
        end
      end
      expected_read_data.push_back(rd);
    endfunction

    function void check_read_data(logic [7:0] actual);
      logic [7:0] want;
      if (expected_read_data.size() == 0) begin
        $display("%0t: read data %02h arrived with no item outstanding", $time, actual);
        failures++;
        return;
      end
      want = expected_read_data.pop_front();
      checked++;
      if (actual !== want) begin
        $display("%0t: read data mismatch, expected %02h, actual %02h", $time, want, actual);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'h0000;   // [7:0] address, [15:8] write_data
  logic        in_tuser = 1'b0;       // [0] mode (0 read, 1 write)
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;             // [7:0] read_data

  read_data_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int items_sent = 0;
  bit steady = 1'b0;          // when set, neither side idles
  bit hold_request = 1'b0;    // asks the receiver for one long hold-off

  sector_disk_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Handshakes are observed at the rising edge, before the block's own updates land.
  // Every accepted item is fed to the predictor and every accepted result is checked.
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_access(in_tuser, in_tdata[7:0], in_tdata[15:8]);
      if (out_tvalid && out_tready) sb.check_read_data(out_tdata);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles with %0d results outstanding",
               $time, cycle_count, sb.expected_read_data.size());
      $display("sector_disk_controller regression: fail");
      $finish;
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Receiver: random stalls before each result, and one long hold-off on request so that
  // the single-item pipeline stays full and the input side backs up.
  initial begin
    int stall;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_gap();
      end
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  // Offers one item after a random gap and returns at the edge where it is taken. Valid
  // stays high afterwards so that back-to-back items need no second assignment.
  task automatic send_access(input bit is_write, input logic [7:0] addr,
                             input logic [7:0] data);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= is_write;
    in_tdata <= {data, addr};
    do @(posedge clk); while (in_tready !== 1'b1);
    items_sent++;
  endtask

  task automatic bus_write(input logic [7:0] addr, input logic [7:0] data);
    send_access(1'b1, addr, data);
  endtask

  // The write data lane is don't-care on reads, so it carries random bits.
  task automatic bus_read(input logic [7:0] addr);
    send_access(1'b0, addr, 8'($urandom_range(0, 255)));
  endtask

  task automatic set_sector(input logic [15:0] sector);
    bus_write(sdc_pkg::ADDR_SECTOR_LO, sector[7:0]);
    bus_write(sdc_pkg::ADDR_SECTOR_HI, sector[15:8]);
  endtask

  // Writes a command and reads the status it left behind.
  task automatic issue(input logic [7:0] cmd);
    bus_write(sdc_pkg::ADDR_COMMAND, cmd);
    bus_read(sdc_pkg::ADDR_COMMAND);
  endtask

  // Drops valid and waits until every result is back before the register changes.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_read_data.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_disk_present(input bit value);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    sb.set_disk_present(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly low sectors so reads find written data, some around the top of the disk,
  // and now and then any 16-bit value.
  function automatic logic [15:0] pick_sector();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($urandom_range(0, 15));
    if (r < 9) return 16'($urandom_range(sdc_pkg::MAX_SECTOR - 3, sdc_pkg::MAX_SECTOR + 2));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Random traffic, mostly well-formed command sequences with random content, the rest
  // single register accesses and raw noise over the whole address window.
  task automatic run_random(input int count);
    int stop_at;
    int n;
    int r;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          set_sector(pick_sector());
          n = $urandom_range(1, 4);
          repeat (n) bus_write(8'($urandom_range(0, sdc_pkg::SECTOR_BYTES - 1)),
                               8'($urandom_range(0, 255)));
          issue(sdc_pkg::CMD_SECTOR_WRITE);
        end
        3, 4: begin
          set_sector(pick_sector());
          issue(sdc_pkg::CMD_SECTOR_READ);
          n = $urandom_range(1, 3);
          repeat (n) bus_read(8'($urandom_range(0, sdc_pkg::SECTOR_BYTES - 1)));
        end
        5: begin
          r = $urandom_range(0, 2);
          issue(r == 0 ? sdc_pkg::CMD_LABEL_LOAD :
                (r == 1 ? sdc_pkg::CMD_LABEL_SAVE : sdc_pkg::CMD_SERIAL));
          bus_read(8'($urandom_range(0, 15)));
          bus_read(8'($urandom_range(0, 15)));
        end
        6: begin
          r = $urandom_range(0, 1);
          bus_write(r ? sdc_pkg::ADDR_SECTOR_HI : sdc_pkg::ADDR_SECTOR_LO,
                    8'($urandom_range(0, 255)));
          bus_read(sdc_pkg::ADDR_SECTOR_LO);
          bus_read(sdc_pkg::ADDR_SECTOR_HI);
        end
        7: begin
          n = $urandom_range(1, 3);
          repeat (n) send_access(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
        end
        8: begin
          bus_read(8'($urandom_range(0, sdc_pkg::SECTOR_BYTES - 1)));
          bus_read(8'($urandom_range(sdc_pkg::ADDR_COMMAND + 1, 255)));
        end
        default: issue(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // No disk: even the do-nothing command fails, and unmapped addresses ignore writes.
    write_disk_present(1'b0);
    issue(sdc_pkg::CMD_NOP);
    bus_write(8'hFF, 8'hFF);
    bus_read(8'hFF);

    write_disk_present(1'b1);
    // Reading an empty disk fails; then the very last sector is written, which makes
    // every lower sector readable as zeros.
    set_sector(16'd5);
    issue(sdc_pkg::CMD_SECTOR_READ);
    bus_write(8'd127, 8'hA5);
    set_sector(16'(sdc_pkg::MAX_SECTOR));
    issue(sdc_pkg::CMD_SECTOR_WRITE);
    // One past the top sector is refused.
    bus_write(sdc_pkg::ADDR_SECTOR_LO, 8'h01);
    issue(sdc_pkg::CMD_SECTOR_WRITE);
    // Sector 1 was skipped by the write above.
    bus_write(sdc_pkg::ADDR_SECTOR_HI, 8'h00);
    issue(sdc_pkg::CMD_SECTOR_READ);
    bus_read(8'd127);
    issue(sdc_pkg::CMD_SERIAL);
    bus_read(8'd7);
    issue(CMD_FIRST_UNKNOWN);
    issue(CMD_LAST_UNKNOWN);
    issue(sdc_pkg::CMD_NOP);

    // The long receiver hold-off lands early in this phase.
    hold_request = 1'b1;
    run_random(150);

    steady = 1'b1;
    write_disk_present(1'b0);
    run_random(40);

    steady = 1'b0;
    write_disk_present(1'b1);
    // A label that fills the whole buffer has no terminating zero.
    for (int i = 0; i < sdc_pkg::SECTOR_BYTES; i++)
      bus_write(8'(i), 8'($urandom_range(1, 255)));
    issue(sdc_pkg::CMD_LABEL_SAVE);
    issue(sdc_pkg::CMD_SERIAL);
    issue(sdc_pkg::CMD_LABEL_LOAD);
    bus_read(8'd0);
    bus_read(8'd127);
    steady = 1'b1;
    run_random(30);
    steady = 1'b0;
    run_random(30);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d bus items and %0d commands, %0d of them rejected.",
             sb.accesses, sb.commands, sb.failed_commands);
    $display("Checked %0d read items; the disk grew to %0d sectors.", sb.checked, sb.extent);
    if (sb.failures == 0 && sb.expected_read_data.size() == 0) begin
      $display("sector_disk_controller regression: pass");
    end else begin
      $display("sector_disk_controller regression: fail");
    end
    $finish;
  end

endmodule
